>>> rtl/drkg_pkg.sv
`timescale 1ns / 1ps
// Shared types, permutation tables and helper functions for the DES round key generator.
// No dependencies; every rtl file refers to this package by scoped names.
package drkg_pkg;

   localparam int KEY_W   = 64;
   localparam int HALF_W  = 28;
   localparam int CD_W    = 2 * HALF_W;
   localparam int SUB_W   = 48;
   localparam int RND_W   = 5;
   localparam int ROUNDS  = 16;
   localparam int RIDX_W  = $clog2(ROUNDS);
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 56;

   // PC-1: DES bit numbers, bit 1 is the msb of the key
   localparam logic [6:0] PC1_TAB [CD_W] = '{
      7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
      7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
      7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
      7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39,
      7'd31, 7'd23, 7'd15, 7'd7,  7'd62, 7'd54, 7'd46, 7'd38,
      7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
      7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
   };

   // PC-2: bit numbers into the merged C:D value, bit 1 is its msb
   localparam logic [6:0] PC2_TAB [SUB_W] = '{
      7'd14, 7'd17, 7'd11, 7'd24, 7'd1,  7'd5,  7'd3,  7'd28,
      7'd15, 7'd6,  7'd21, 7'd10, 7'd23, 7'd19, 7'd12, 7'd4,
      7'd26, 7'd8,  7'd16, 7'd7,  7'd27, 7'd20, 7'd13, 7'd2,
      7'd41, 7'd52, 7'd31, 7'd37, 7'd47, 7'd55, 7'd30, 7'd40,
      7'd51, 7'd45, 7'd33, 7'd48, 7'd44, 7'd49, 7'd39, 7'd56,
      7'd34, 7'd53, 7'd46, 7'd42, 7'd50, 7'd36, 7'd29, 7'd32
   };

   // bit r set: round r+1 rotates by two, else by one
   localparam logic [ROUNDS-1:0] ROT_TWO = 16'h7EFC;

   typedef struct packed {
      logic [CD_W-1:0]  cd;
      logic [RND_W-1:0] round_num;
      logic             last;
   } beat_type;

   function automatic logic [CD_W-1:0] pc1(input logic [KEY_W-1:0] key);
      logic [CD_W-1:0] sel;
      sel = '0;
      for (int i = 0; i < CD_W; i++) begin
         sel[CD_W-1-i] = key[6'(7'(KEY_W) - PC1_TAB[i])];
      end
      return sel;
   endfunction

   function automatic logic [SUB_W-1:0] pc2(input logic [CD_W-1:0] cd);
      logic [SUB_W-1:0] sub;
      sub = '0;
      for (int i = 0; i < SUB_W; i++) begin
         sub[SUB_W-1-i] = cd[6'(7'(CD_W) - PC2_TAB[i])];
      end
      return sub;
   endfunction

   function automatic logic [HALF_W-1:0] rotl_half(input logic [HALF_W-1:0] v,
                                                   input logic two);
      return two ? {v[HALF_W-3:0], v[HALF_W-1:HALF_W-2]}
                 : {v[HALF_W-2:0], v[HALF_W-1]};
   endfunction

   function automatic logic [CD_W-1:0] rotl_cd(input logic [CD_W-1:0] cd,
                                               input logic two);
      return {rotl_half(cd[CD_W-1:HALF_W], two), rotl_half(cd[HALF_W-1:0], two)};
   endfunction

endpackage

>>> rtl/drkg_pc1_stage.sv
`timescale 1ns / 1ps
// Input register: applies PC-1 to an accepted key and holds the C:D halves.
// Depends on drkg_pkg.
module drkg_pc1_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [drkg_pkg::KEY_W-1:0] in_key,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [drkg_pkg::CD_W-1:0]  out_cd
);

   logic                      valid_ff, valid_in;
   logic [drkg_pkg::CD_W-1:0] cd_ff, cd_in;
   logic                      take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      cd_in    = cd_ff;
      if (take) begin
         valid_in = 1'b1;
         cd_in    = drkg_pkg::pc1(in_key);
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cd_ff <= cd_in;
   end

   assign out_valid = valid_ff;
   assign out_cd    = cd_ff;

endmodule

>>> rtl/drkg_round_seq.sv
`timescale 1ns / 1ps
// Round sequencer: rotates C:D once per cycle unless stalled, 16 beats per key.
// Depends on drkg_pkg (rotation schedule, beat_type).
module drkg_round_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [drkg_pkg::CD_W-1:0] in_cd,
   output logic                      out_valid,
   input  logic                      out_ready,
   output drkg_pkg::beat_type        out_beat
);

   logic                        busy_ff, busy_in;
   logic [drkg_pkg::RIDX_W-1:0] rnd_ff, rnd_in;
   logic [drkg_pkg::CD_W-1:0]   cd_ff, cd_in;
   logic                        bvalid_ff, bvalid_in;
   drkg_pkg::beat_type          beat_ff, beat_in;

   logic                        adv;
   logic                        issue;
   logic [drkg_pkg::CD_W-1:0]   src_cd;
   logic [drkg_pkg::RIDX_W-1:0] src_rnd;
   logic [drkg_pkg::CD_W-1:0]   rot_cd;
   logic                        is_last;

   assign adv      = !bvalid_ff || out_ready;
   // a new key is taken once busy_ff has cleared after the last round issues
   assign in_ready = adv && !busy_ff;
   assign issue    = adv && (busy_ff || in_valid);
   assign src_cd   = busy_ff ? cd_ff : in_cd;
   assign src_rnd  = busy_ff ? rnd_ff : '0;
   assign rot_cd   = drkg_pkg::rotl_cd(src_cd, drkg_pkg::ROT_TWO[src_rnd]);
   assign is_last  = (src_rnd == drkg_pkg::RIDX_W'(drkg_pkg::ROUNDS - 1));

   always_comb begin
      busy_in   = busy_ff;
      rnd_in    = rnd_ff;
      cd_in     = cd_ff;
      bvalid_in = bvalid_ff;
      beat_in   = beat_ff;
      if (issue) begin
         busy_in           = !is_last;
         rnd_in            = src_rnd + 1'b1;
         cd_in             = rot_cd;
         bvalid_in         = 1'b1;
         beat_in.cd        = rot_cd;
         beat_in.round_num = drkg_pkg::RND_W'(src_rnd) + 1'b1;
         beat_in.last      = is_last;
      end else if (out_ready) begin
         bvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         bvalid_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         bvalid_ff <= bvalid_in;
      end
      rnd_ff  <= rnd_in;
      cd_ff   <= cd_in;
      beat_ff <= beat_in;
   end

   assign out_valid = bvalid_ff;
   assign out_beat  = beat_ff;

endmodule

>>> rtl/drkg_pc2_stage.sv
`timescale 1ns / 1ps
// Output register: applies PC-2 to a rotated C:D beat and holds the round key.
// Depends on drkg_pkg.
module drkg_pc2_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  drkg_pkg::beat_type         in_beat,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [drkg_pkg::SUB_W-1:0] out_key,
   output logic [drkg_pkg::RND_W-1:0] out_round,
   output logic                       out_last
);

   logic                       valid_ff, valid_in;
   logic [drkg_pkg::SUB_W-1:0] key_ff, key_in;
   logic [drkg_pkg::RND_W-1:0] round_ff, round_in;
   logic                       last_ff, last_in;
   logic                       take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      round_in = round_ff;
      last_in  = last_ff;
      if (take) begin
         valid_in = 1'b1;
         key_in   = drkg_pkg::pc2(in_beat.cd);
         round_in = in_beat.round_num;
         last_in  = in_beat.last;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff   <= key_in;
      round_ff <= round_in;
      last_ff  <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_key   = key_ff;
   assign out_round = round_ff;
   assign out_last  = last_ff;

endmodule

>>> rtl/des_round_key_generator.sv
`timescale 1ns / 1ps
// DES key schedule. One 64-bit key beat in on the req_ channel (DES bit 1 is
// req_tdata[63]); sixteen subkey beats out on the rsp_ channel, rounds 1..16
// in order, rsp_tlast high on round 16.
// Pipeline: PC-1 input register -> round sequencer (one rotation per cycle)
// -> PC-2 output register, all held while rsp_tready is low. Round 1 of a key
// reaches rsp_ via the beat and PC-2 registers; rounds follow one per cycle.
// The sequencer issues one round per cycle while not stalled and takes no
// new key until the last round of the current key has issued. The next key
// can wait in the input register meanwhile, so successive keys stream with
// no gap between the last round of one key and the first round of the next.
// A low rsp_tready holds every stage in place; the stall backs up into
// req_tready and no beat is dropped or repeated.
// Reset clears all valid flags and the sequencer; a key in flight is lost.
// Nothing is carried from one key to the next.
// Depends on drkg_pkg, drkg_pc1_stage, drkg_round_seq, drkg_pc2_stage.
module des_round_key_generator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [drkg_pkg::REQ_TDATA_W-1:0] req_tdata,  // [63:0] cipher_key
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [drkg_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // [47:0] subkey,
                                                        // [52:48] round_number,
                                                        // [55:53] zero
   output logic                             rsp_tlast   // last_round
);

   logic                       p1_valid, p1_ready;
   logic [drkg_pkg::CD_W-1:0]  p1_cd;
   logic                       sq_valid, sq_ready;
   drkg_pkg::beat_type         sq_beat;
   logic [drkg_pkg::SUB_W-1:0] out_key;
   logic [drkg_pkg::RND_W-1:0] out_round;

   drkg_pc1_stage u_pc1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_key    (req_tdata),
      .out_valid (p1_valid),
      .out_ready (p1_ready),
      .out_cd    (p1_cd)
   );

   drkg_round_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p1_valid),
      .in_ready  (p1_ready),
      .in_cd     (p1_cd),
      .out_valid (sq_valid),
      .out_ready (sq_ready),
      .out_beat  (sq_beat)
   );

   drkg_pc2_stage u_pc2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_ready  (sq_ready),
      .in_beat   (sq_beat),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_key   (out_key),
      .out_round (out_round),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, out_round, out_key};

endmodule
